// ===== rtl/core/pps_pkg.sv =====
package pps_pkg;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic load;
        logic clear;
        logic run;
    } cell_cmd_t;

endpackage

// ===== rtl/core/sched_if.sv =====
interface sched_in_if #(parameter int TIME_BITS = 16);
    logic                            valid;
    logic                            ready;
    logic [pps_pkg::MODE_W-1:0]      mode;
    logic [pps_pkg::ID_W-1:0]        proc_id;
    logic [TIME_BITS-1:0]            arrival;
    logic [pps_pkg::BURST_W-1:0]     burst;
    logic [pps_pkg::PRIO_W-1:0]      prio;

    modport source (output valid, output mode, output proc_id, output arrival,
                    output burst, output prio, input ready);
    modport sink   (input valid, input mode, input proc_id, input arrival,
                    input burst, input prio, output ready);
endinterface

interface sched_out_if #(parameter int TIME_BITS = 16);
    logic                        valid;
    logic                        ready;
    logic [TIME_BITS-1:0]        tick_time;
    logic [pps_pkg::ID_W-1:0]    running_id;
    logic                        idle;
    logic                        finished;
    logic [TIME_BITS-1:0]        turnaround;
    logic [TIME_BITS-1:0]        waiting;
    logic [TIME_BITS-1:0]        response;
    logic                        all_done;

    modport source (output valid, output tick_time, output running_id, output idle,
                    output finished, output turnaround, output waiting,
                    output response, output all_done, input ready);
    modport sink   (input valid, input tick_time, input running_id, input idle,
                    input finished, input turnaround, input waiting,
                    input response, input all_done, output ready);
endinterface

// ===== rtl/core/pps_cell.sv =====
module pps_cell #(
    parameter int IW        = 4,
    parameter int TIME_BITS = 16,
    parameter int IDX       = 0
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pps_pkg::cell_cmd_t            cmd,
    input  logic [IW-1:0]                 load_idx,
    input  logic [IW-1:0]                 sel_idx,
    input  logic [TIME_BITS-1:0]          now,
    input  logic [pps_pkg::ID_W-1:0]      ld_id,
    input  logic [TIME_BITS-1:0]          ld_arr,
    input  logic [pps_pkg::BURST_W-1:0]   ld_burst,
    input  logic [pps_pkg::PRIO_W-1:0]    ld_prio,
    input  logic                          in_found,
    input  logic [IW-1:0]                 in_idx,
    input  logic [pps_pkg::PRIO_W-1:0]    in_prio,
    input  logic [TIME_BITS-1:0]          in_arr,
    input  logic [pps_pkg::ID_W-1:0]      in_id,
    input  logic [pps_pkg::BURST_W-1:0]   in_burst,
    input  logic [pps_pkg::BURST_W-1:0]   in_rem,
    input  logic [TIME_BITS-1:0]          in_start,
    input  logic                          in_started,
    output logic                          out_found,
    output logic [IW-1:0]                 out_idx,
    output logic [pps_pkg::PRIO_W-1:0]    out_prio,
    output logic [TIME_BITS-1:0]          out_arr,
    output logic [pps_pkg::ID_W-1:0]      out_id,
    output logic [pps_pkg::BURST_W-1:0]   out_burst,
    output logic [pps_pkg::BURST_W-1:0]   out_rem,
    output logic [TIME_BITS-1:0]          out_start,
    output logic                          out_started
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic                        valid_reg;
    logic                        done_reg;
    logic                        started_reg;
    logic [pps_pkg::ID_W-1:0]    id_reg;
    logic [TIME_BITS-1:0]        arr_reg;
    logic [pps_pkg::BURST_W-1:0] burst_reg;
    logic [pps_pkg::PRIO_W-1:0]  prio_reg;
    logic [pps_pkg::BURST_W-1:0] rem_reg;
    logic [TIME_BITS-1:0]        start_reg;
    logic [pps_pkg::BURST_W-1:0] rem_next;
    logic                        found_reg;
    logic [IW-1:0]               c_idx_reg;
    logic [pps_pkg::PRIO_W-1:0]  c_prio_reg;
    logic [TIME_BITS-1:0]        c_arr_reg;
    logic [pps_pkg::ID_W-1:0]    c_id_reg;
    logic [pps_pkg::BURST_W-1:0] c_burst_reg;
    logic [pps_pkg::BURST_W-1:0] c_rem_reg;
    logic [TIME_BITS-1:0]        c_start_reg;
    logic                        c_started_reg;
    logic                        eligible;
    logic                        better;
    logic                        do_load;
    logic                        do_run;

    assign eligible = valid_reg && !done_reg && (arr_reg <= now);
    assign better   = eligible && (!in_found || (prio_reg < in_prio) ||
                      ((prio_reg == in_prio) && (arr_reg < in_arr)));
    assign do_load  = cmd.load && (load_idx == MY_IDX);
    assign do_run   = cmd.run && (sel_idx == MY_IDX);
    assign rem_next = (rem_reg != '0) ? rem_reg - 1'b1 : rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            done_reg    <= 1'b0;
            started_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            found_reg <= better || in_found;
            if (cmd.clear)
            begin
                valid_reg <= 1'b0;
            end
            else if (do_load)
            begin
                valid_reg   <= 1'b1;
                done_reg    <= 1'b0;
                started_reg <= 1'b0;
            end
            else if (do_run)
            begin
                started_reg <= 1'b1;
                if (rem_next == '0)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            id_reg    <= ld_id;
            arr_reg   <= ld_arr;
            burst_reg <= ld_burst;
            prio_reg  <= ld_prio;
            rem_reg   <= ld_burst;
            start_reg <= '0;
        end
        else if (do_run)
        begin
            rem_reg <= rem_next;
            if (!started_reg)
            begin
                start_reg <= now;
            end
        end
        if (better)
        begin
            c_idx_reg     <= MY_IDX;
            c_prio_reg    <= prio_reg;
            c_arr_reg     <= arr_reg;
            c_id_reg      <= id_reg;
            c_burst_reg   <= burst_reg;
            c_rem_reg     <= rem_reg;
            c_start_reg   <= start_reg;
            c_started_reg <= started_reg;
        end
        else
        begin
            c_idx_reg     <= in_idx;
            c_prio_reg    <= in_prio;
            c_arr_reg     <= in_arr;
            c_id_reg      <= in_id;
            c_burst_reg   <= in_burst;
            c_rem_reg     <= in_rem;
            c_start_reg   <= in_start;
            c_started_reg <= in_started;
        end
    end

    assign out_found   = found_reg;
    assign out_idx     = c_idx_reg;
    assign out_prio    = c_prio_reg;
    assign out_arr     = c_arr_reg;
    assign out_id      = c_id_reg;
    assign out_burst   = c_burst_reg;
    assign out_rem     = c_rem_reg;
    assign out_start   = c_start_reg;
    assign out_started = c_started_reg;

endmodule

// ===== rtl/core/preemptive_priority_scheduler.sv =====
// Load and clear words produce no result. A tick word lets the best candidate ripple
// through the row of process cells, then commits it, writing the result word to the
// output register; the commit waits while the previous result word is still unread.
// One word is in flight at a time, so a new word is taken only after a tick commits.
// Reset (rst_n low, asynchronous) empties the table and zeroes the clock and counts.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    sched_in_if.sink    in_ch,
    sched_out_if.source out_ch
);

    localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW = $clog2(MAX_PROCS + 1);
    localparam int WW = (TIME_BITS > pps_pkg::BURST_W) ? TIME_BITS : pps_pkg::BURST_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FINAL = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [IW-1:0]               scan_cnt_reg, scan_cnt_next;
    logic [CW-1:0]               count_reg;
    logic [CW-1:0]               done_cnt_reg;
    logic [CW-1:0]               done_cnt_next;
    logic [TIME_BITS-1:0]        now_reg;
    logic [TIME_BITS-1:0]        now_next;
    logic                        out_valid_reg;
    logic [TIME_BITS-1:0]        tick_time_reg;
    logic [pps_pkg::ID_W-1:0]    running_id_reg;
    logic                        idle_reg;
    logic                        finished_reg;
    logic [TIME_BITS-1:0]        turnaround_reg;
    logic [TIME_BITS-1:0]        waiting_reg;
    logic [TIME_BITS-1:0]        response_reg;
    logic                        all_done_reg;

    logic                        in_fire;
    logic                        final_fire;
    pps_pkg::cell_cmd_t          cmd;

    logic                        ch_found   [MAX_PROCS+1];
    logic [IW-1:0]               ch_idx     [MAX_PROCS+1];
    logic [pps_pkg::PRIO_W-1:0]  ch_prio    [MAX_PROCS+1];
    logic [TIME_BITS-1:0]        ch_arr     [MAX_PROCS+1];
    logic [pps_pkg::ID_W-1:0]    ch_id      [MAX_PROCS+1];
    logic [pps_pkg::BURST_W-1:0] ch_burst   [MAX_PROCS+1];
    logic [pps_pkg::BURST_W-1:0] ch_rem     [MAX_PROCS+1];
    logic [TIME_BITS-1:0]        ch_start   [MAX_PROCS+1];
    logic                        ch_started [MAX_PROCS+1];

    logic                        w_found;
    logic [pps_pkg::BURST_W-1:0] rem_dec;
    logic                        w_fin;
    logic [TIME_BITS-1:0]        tat;
    logic [WW-1:0]               tat_w;
    logic [WW-1:0]               burst_w;
    logic [TIME_BITS-1:0]        wt;
    logic [TIME_BITS-1:0]        start_eff;
    logic [TIME_BITS-1:0]        resp;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign final_fire  = (state_reg == ST_FINAL) && (!out_valid_reg || out_ch.ready);

    assign cmd.load  = in_fire && (in_ch.mode == pps_pkg::MODE_LOAD) &&
                       (count_reg < CW'(MAX_PROCS));
    assign cmd.clear = in_fire && (in_ch.mode == pps_pkg::MODE_CLEAR);
    assign cmd.run   = final_fire && w_found;

    assign ch_found[0]   = 1'b0;
    assign ch_idx[0]     = '0;
    assign ch_prio[0]    = '0;
    assign ch_arr[0]     = '0;
    assign ch_id[0]      = '0;
    assign ch_burst[0]   = '0;
    assign ch_rem[0]     = '0;
    assign ch_start[0]   = '0;
    assign ch_started[0] = 1'b0;

    for (genvar k = 0; k < MAX_PROCS; k++)
    begin : g_cells
        pps_cell #(
            .IW        (IW),
            .TIME_BITS (TIME_BITS),
            .IDX       (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .load_idx    (count_reg[IW-1:0]),
            .sel_idx     (ch_idx[MAX_PROCS]),
            .now         (now_reg),
            .ld_id       (in_ch.proc_id),
            .ld_arr      (in_ch.arrival),
            .ld_burst    (in_ch.burst),
            .ld_prio     (in_ch.prio),
            .in_found    (ch_found[k]),
            .in_idx      (ch_idx[k]),
            .in_prio     (ch_prio[k]),
            .in_arr      (ch_arr[k]),
            .in_id       (ch_id[k]),
            .in_burst    (ch_burst[k]),
            .in_rem      (ch_rem[k]),
            .in_start    (ch_start[k]),
            .in_started  (ch_started[k]),
            .out_found   (ch_found[k+1]),
            .out_idx     (ch_idx[k+1]),
            .out_prio    (ch_prio[k+1]),
            .out_arr     (ch_arr[k+1]),
            .out_id      (ch_id[k+1]),
            .out_burst   (ch_burst[k+1]),
            .out_rem     (ch_rem[k+1]),
            .out_start   (ch_start[k+1]),
            .out_started (ch_started[k+1])
        );
    end

    assign w_found   = ch_found[MAX_PROCS];
    assign rem_dec   = (ch_rem[MAX_PROCS] != '0) ? ch_rem[MAX_PROCS] - 1'b1 : '0;
    assign w_fin     = w_found && (rem_dec == '0);
    assign now_next  = (now_reg == TIME_MAX) ? now_reg : now_reg + 1'b1;
    assign tat       = now_next - ch_arr[MAX_PROCS];
    assign tat_w     = WW'(tat);
    assign burst_w   = WW'(ch_burst[MAX_PROCS]);
    assign wt        = (tat_w > burst_w) ? TIME_BITS'(tat_w - burst_w) : '0;
    assign start_eff = ch_started[MAX_PROCS] ? ch_start[MAX_PROCS] : now_reg;
    assign resp      = start_eff - ch_arr[MAX_PROCS];
    assign done_cnt_next = done_cnt_reg + CW'(w_fin);

    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (in_fire && (in_ch.mode == pps_pkg::MODE_TICK))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == IW'(MAX_PROCS - 1))
                begin
                    state_next    = ST_FINAL;
                    scan_cnt_next = '0;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_FINAL:
            begin
                if (final_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                scan_cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            count_reg     <= '0;
            done_cnt_reg  <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_cnt_reg <= scan_cnt_next;
            if (cmd.clear)
            begin
                count_reg    <= '0;
                done_cnt_reg <= '0;
                now_reg      <= '0;
            end
            else if (cmd.load)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (final_fire)
            begin
                now_reg      <= now_next;
                done_cnt_reg <= done_cnt_next;
            end
            if (final_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (final_fire)
        begin
            tick_time_reg  <= now_reg;
            running_id_reg <= w_found ? ch_id[MAX_PROCS] : '0;
            idle_reg       <= !w_found;
            finished_reg   <= w_fin;
            turnaround_reg <= w_fin ? tat : '0;
            waiting_reg    <= w_fin ? wt : '0;
            response_reg   <= w_fin ? resp : '0;
            all_done_reg   <= (done_cnt_next >= count_reg);
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.tick_time  = tick_time_reg;
    assign out_ch.running_id = running_id_reg;
    assign out_ch.idle       = idle_reg;
    assign out_ch.finished   = finished_reg;
    assign out_ch.turnaround = turnaround_reg;
    assign out_ch.waiting    = waiting_reg;
    assign out_ch.response   = response_reg;
    assign out_ch.all_done   = all_done_reg;

    a_done_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        done_cnt_reg <= count_reg)
        else $error("completed count exceeds loaded count");

    a_final_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        final_fire |=> out_ch.valid && (state_reg == ST_IDLE))
        else $error("committed tick left no result word");

    a_scan_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_SCAN) |-> (scan_cnt_reg == '0))
        else $error("scan counter running outside the scan");

    a_run_is_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.run |-> (CW'(ch_idx[MAX_PROCS]) < count_reg))
        else $error("selected process lies beyond the loaded table");

endmodule

// ===== test/tb_preemptive_priority_scheduler.sv =====
module tb_preemptive_priority_scheduler;

    localparam int NPROC     = 16;
    localparam int TBITS     = 16;
    localparam int WORDS     = 850;
    localparam int STALL_MAX = 5000;

    typedef logic [TBITS-1:0] tval_t;
    typedef logic [pps_pkg::ID_W-1:0] id_t;
    typedef logic [pps_pkg::BURST_W-1:0] burst_t;
    typedef logic [pps_pkg::PRIO_W-1:0] prio_t;
    typedef logic [pps_pkg::MODE_W-1:0] mode_t;

    typedef struct packed {
        tval_t        tick_time;
        id_t          running_id;
        logic         idle;
        logic         finished;
        tval_t        turnaround;
        tval_t        waiting;
        tval_t        response;
        logic         all_done;
    } tick_report_t;

    class sched_scoreboard;
        tick_report_t pending[$];
        id_t                ids[NPROC];
        tval_t              arrive[NPROC];
        burst_t             need[NPROC];
        burst_t             left[NPROC];
        prio_t              level[NPROC];
        tval_t              first_run[NPROC];
        bit                 ran[NPROC];
        bit                 done[NPROC];
        int                 loaded;
        int                 completed;
        tval_t              now;
        int                 errors;
        int                 ticks_seen;
        int                 finishes_seen;
        int                 loads_taken;
        int                 loads_dropped;

        function void wipe();
            loaded = 0;
            completed = 0;
            now = '0;
            for (int k = 0; k < NPROC; k++)
            begin
                ran[k] = 0;
                done[k] = 0;
            end
        endfunction

        function bit all_finished();
            return completed >= loaded;
        endfunction

        function void note_word(mode_t md, id_t id, tval_t arr, burst_t bur, prio_t pr);
            tick_report_t r;
            int best;
            tval_t nxt;
            tval_t tat;
            best = -1;
            r = '0;
            case (md)
                pps_pkg::MODE_LOAD:
                begin
                    if (loaded < NPROC)
                    begin
                        ids[loaded] = id;
                        arrive[loaded] = arr;
                        need[loaded] = bur;
                        left[loaded] = bur;
                        level[loaded] = pr;
                        ran[loaded] = 0;
                        done[loaded] = 0;
                        loaded++;
                        loads_taken++;
                    end
                    else
                        loads_dropped++;
                end
                pps_pkg::MODE_TICK:
                begin
                    for (int k = 0; k < loaded; k++)
                    begin
                        if (done[k] || arrive[k] > now)
                            continue;
                        if (best < 0 || level[k] < level[best] ||
                            (level[k] == level[best] && arrive[k] < arrive[best]))
                            best = k;
                    end
                    nxt = (now != '1) ? now + 1'b1 : now;
                    r.tick_time = now;
                    if (best < 0)
                        r.idle = 1;
                    else
                    begin
                        r.running_id = ids[best];
                        if (!ran[best])
                        begin
                            ran[best] = 1;
                            first_run[best] = now;
                        end
                        if (left[best] > 0)
                            left[best]--;
                        if (left[best] == 0)
                        begin
                            tat = nxt - arrive[best];
                            done[best] = 1;
                            completed++;
                            r.finished = 1;
                            r.turnaround = tat;
                            r.waiting = (tat > need[best]) ? tat - need[best] : '0;
                            r.response = first_run[best] - arrive[best];
                        end
                    end
                    now = nxt;
                    r.all_done = completed >= loaded;
                    pending.push_back(r);
                end
                pps_pkg::MODE_CLEAR:
                    wipe();
                default:
                    ;
            endcase
        endfunction

        function void check_word(tick_report_t got);
            tick_report_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: %p", got);
                return;
            end
            want = pending.pop_front();
            ticks_seen++;
            if (got.finished)
                finishes_seen++;
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch at tick %0d: expected %p, got %p",
                             want.tick_time, want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_gaps;
    int   stall;
    int   words_sent;

    sched_in_if  #(.TIME_BITS(TBITS)) in_ch();
    sched_out_if #(.TIME_BITS(TBITS)) out_ch();

    sched_scoreboard sb;

    preemptive_priority_scheduler #(.MAX_PROCS(NPROC), .TIME_BITS(TBITS)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .out_ch(out_ch)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(negedge clk)
    begin
        if (rst_n)
            out_ch.ready <= (gap_len() == 0);
        else
            out_ch.ready <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
                sb.check_word({out_ch.tick_time, out_ch.running_id, out_ch.idle,
                               out_ch.finished, out_ch.turnaround, out_ch.waiting,
                               out_ch.response, out_ch.all_done});
            if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
                stall = 0;
            else
                stall++;
            if (stall >= STALL_MAX)
            begin
                $display("watchdog: no progress for %0d cycles", STALL_MAX);
                $display("tb_preemptive_priority_scheduler: FAIL");
                $finish;
            end
        end
    end

    task automatic send(mode_t md, id_t id, tval_t arr, burst_t bur, prio_t pr);
        int g;
        g = gap_len();
        @(negedge clk);
        if (g > 0)
        begin
            in_ch.valid = 0;
            repeat (g) @(negedge clk);
        end
        in_ch.valid = 1;
        in_ch.mode = md;
        in_ch.proc_id = id;
        in_ch.arrival = arr;
        in_ch.burst = bur;
        in_ch.prio = pr;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_word(md, id, arr, bur, pr);
        words_sent++;
    endtask

    task automatic load(id_t id, tval_t arr, burst_t bur, prio_t pr);
        send(pps_pkg::MODE_LOAD, id, arr, bur, pr);
    endtask

    task automatic send_filler(mode_t md);
        send(md, id_t'($urandom), tval_t'($urandom), burst_t'($urandom), prio_t'($urandom));
    endtask

    task automatic tick();
        send_filler(pps_pkg::MODE_TICK);
    endtask

    task automatic clear_table();
        send_filler(pps_pkg::MODE_CLEAR);
    endtask

    task automatic random_batch();
        int n;
        int extra;
        int limit;
        int r;
        tval_t arr;
        burst_t bur;
        prio_t pr;
        if ($urandom_range(0, 3) != 0)
            clear_table();
        n = $urandom_range(1, 19);
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            arr = (r < 90) ? tval_t'($urandom_range(0, 12)) : tval_t'($urandom);
            r = $urandom_range(0, 99);
            if (r < 90)
                bur = burst_t'($urandom_range(1, 5));
            else if (r < 97)
                bur = burst_t'($urandom);
            else
                bur = '0;
            if ($urandom_range(0, 3) == 0)
                pr = prio_t'($urandom);
            else
                pr = prio_t'($urandom_range(0, 3));
            load(id_t'($urandom), arr, bur, pr);
        end
        limit = $urandom_range(10, 70);
        extra = $urandom_range(0, 2);
        for (int t = 0; t < limit; t++)
        begin
            if ($urandom_range(0, 40) == 0)
                send_filler(pps_pkg::MODE_UNUSED);
            tick();
            if (sb.all_finished())
            begin
                if (extra == 0)
                    break;
                extra--;
            end
        end
    endtask

    initial
    begin
        sb = new();
        sb.wipe();
        clk = 0;
        rst_n = 0;
        words_sent = 0;
        no_gaps = 0;
        in_ch.valid = 0;
        in_ch.mode = pps_pkg::MODE_LOAD;
        in_ch.proc_id = '0;
        in_ch.arrival = '0;
        in_ch.burst = '0;
        in_ch.prio = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        tick();
        load(8'hFF, 16'h0000, 16'h0000, 8'h00);
        load(8'h00, 16'hFFFF, 16'hFFFF, 8'hFF);
        load(8'h11, 16'h0001, 16'h0002, 8'h05);
        load(8'h22, 16'h0001, 16'h0002, 8'h05);
        load(8'h33, 16'h0000, 16'h0001, 8'h05);
        load(8'h44, 16'h0002, 16'h0001, 8'h01);
        repeat (9) tick();
        send(pps_pkg::MODE_UNUSED, 8'hAA, 16'h5555, 16'hAAAA, 8'h55);
        clear_table();
        load(8'h5A, 16'h0003, 16'h7FFF, 8'h80);
        repeat (5) tick();
        clear_table();
        tick();

        while (words_sent < WORDS)
        begin
            if ($urandom_range(0, 5) == 0)
                no_gaps = !no_gaps;
            random_batch();
        end

        @(negedge clk);
        in_ch.valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d words: %0d loads taken, %0d dropped on a full table.",
                 words_sent, sb.loads_taken, sb.loads_dropped);
        $display("Checked %0d tick results, %0d of them with a completion.",
                 sb.ticks_seen, sb.finishes_seen);
        if (sb.errors == 0)
            $display("tb_preemptive_priority_scheduler: PASS");
        else
        begin
            $display("%0d mismatches in total.", sb.errors);
            $display("tb_preemptive_priority_scheduler: FAIL");
        end
        $finish;
    end

endmodule
